@@ src/bilinear_wrap_texture_sampler_unit_defines.svh @@
// Assertion macros used by the sampler controller.
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked property, switched off while reset is high
`define BTSU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("btsu assertion failed");
// clocked property that must also hold through reset
`define BTSU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("btsu assertion failed");
`else
`define BTSU_ASSERT(label, clk, rst, prop)
`define BTSU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ src/btsu_pkg.sv @@
`default_nettype none

package btsu_pkg;

   localparam int COORD_W = 24;
   localparam int COLOR_W = 8;
   localparam int SIZE_W  = 9;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [SIZE_W-1:0]  csr_data_type;
   typedef logic [0:0]         csr_index_type;
   typedef logic [1:0]         corner_type;

   localparam size_type SIZE_RESET = 9'd256;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam csr_index_type CSR_IMAGE_WIDTH  = 1'b0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 1'b1;

   localparam corner_type CORNER_UL = 2'd0;
   localparam corner_type CORNER_UR = 2'd1;
   localparam corner_type CORNER_LL = 2'd2;
   localparam corner_type CORNER_LR = 2'd3;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       mem_rd;
      corner_type corner;
      logic       a_init;
      logic       a_add;
      logic       b_init;
      logic       b_add;
      logic       t_init;
      logic       t_add;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_done;
   } status_type;

   // zero reads as one, anything above the maximum saturates
   function automatic size_type clamp_size(input size_type v, input int unsigned maxv);
      size_type r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > maxv) begin
         r = SIZE_W'(maxv);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/btsu_req_if.sv @@
`default_nettype none

interface btsu_req_if;
   import btsu_pkg::*;

   logic      valid;
   logic      ready;
   logic      func;
   coord_type coord_x;
   coord_type coord_y;
   color_type write_red;
   color_type write_green;
   color_type write_blue;

   modport source (
      output valid, func, coord_x, coord_y, write_red, write_green, write_blue,
      input  ready
   );
   modport sink (
      input  valid, func, coord_x, coord_y, write_red, write_green, write_blue,
      output ready
   );
endinterface

`default_nettype wire

@@ src/btsu_rsp_if.sv @@
`default_nettype none

interface btsu_rsp_if;
   import btsu_pkg::*;

   logic      valid;
   logic      ready;
   color_type sample_red;
   color_type sample_green;
   color_type sample_blue;

   modport source (
      output valid, sample_red, sample_green, sample_blue,
      input  ready
   );
   modport sink (
      input  valid, sample_red, sample_green, sample_blue,
      output ready
   );
endinterface

`default_nettype wire

@@ src/btsu_mod.sv @@
`default_nettype none

// Bit-serial signed modulo: result = value mod modulus, in 0..modulus-1.
module btsu_mod #(
   parameter int IW = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [IW-1:0]     value,
   input  btsu_pkg::size_type     modulus,
   output logic                   done,
   output btsu_pkg::size_type     result
);
   import btsu_pkg::*;

   localparam int CW = $clog2(IW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [IW-1:0] mag_ff, mag_in;
   size_type      rem_ff, rem_in;
   size_type      m_ff, m_in;
   size_type      result_ff, result_in;

   logic [SIZE_W:0] trial;
   logic [SIZE_W:0] diff;
   logic            fits;

   assign trial = {rem_ff, mag_ff[IW-1]};
   assign diff  = trial - {1'b0, m_ff};
   assign fits  = (trial >= {1'b0, m_ff});

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      m_in      = m_ff;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = value[IW-1];
         mag_in  = value[IW-1] ? (~value) + IW'(1) : value;
         rem_in  = '0;
         cnt_in  = CW'(IW);
         m_in    = modulus;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff - CW'(1);
         end else begin
            // count exhausted: raise done; a negative operand folds the magnitude remainder back into range
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = (neg_ff && rem_ff != '0) ? m_ff - rem_ff : rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      rem_ff    <= rem_in;
      m_ff      <= m_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

@@ src/btsu_datapath.sv @@
`default_nettype none

module btsu_datapath #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int FRAC_BITS    = 8,
   parameter int CHANNEL_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  btsu_pkg::cmd_type      cmd,
   output btsu_pkg::status_type   status,
   input  wire logic              req_func,
   input  btsu_pkg::coord_type    req_coord_x,
   input  btsu_pkg::coord_type    req_coord_y,
   input  btsu_pkg::color_type    req_write_red,
   input  btsu_pkg::color_type    req_write_green,
   input  btsu_pkg::color_type    req_write_blue,
   output btsu_pkg::color_type    rsp_sample_red,
   output btsu_pkg::color_type    rsp_sample_green,
   output btsu_pkg::color_type    rsp_sample_blue,
   input  wire logic              csr_write_enable,
   input  btsu_pkg::csr_index_type csr_index,
   input  btsu_pkg::csr_data_type csr_write_data
);
   import btsu_pkg::*;

   localparam int IW    = COORD_W - FRAC_BITS;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int TXW   = 3 * CHANNEL_BITS;
   localparam int WW    = FRAC_BITS + 1;
   localparam int VW    = CHANNEL_BITS + FRAC_BITS;
   localparam int TW    = CHANNEL_BITS + 2 * FRAC_BITS;

   localparam logic [WW-1:0] SCALE     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [TW-1:0] HALF      = TW'(1) << (2 * FRAC_BITS - 1);
   localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // image size registers
   size_type width_ff, width_in;
   size_type height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = clamp_size(csr_write_data, MAX_WIDTH);
            CSR_IMAGE_HEIGHT: height_in = clamp_size(csr_write_data, MAX_HEIGHT);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_size(SIZE_RESET, MAX_WIDTH);
         height_ff <= clamp_size(SIZE_RESET, MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // integer parts, floor of the fixed-point coordinate
   logic [IW-1:0] ix, iy;
   assign ix = req_coord_x[COORD_W-1:FRAC_BITS];
   assign iy = req_coord_y[COORD_W-1:FRAC_BITS];

   logic          wr_in_range;
   logic [AW-1:0] wr_addr;
   logic [TXW-1:0] wr_data;

   assign wr_in_range = !ix[IW-1] && !iy[IW-1] &&
                        (ix < IW'(width_ff)) && (iy < IW'(height_ff));
   assign wr_addr = AW'(iy) * ROW_PITCH + AW'(ix);
   assign wr_data = {CHANNEL_BITS'(req_write_blue), CHANNEL_BITS'(req_write_green),
                     CHANNEL_BITS'(req_write_red)};

   // clearing sweep address
   logic [AW-1:0] clr_ff, clr_in;
   assign clr_in = cmd.clear ? clr_ff + AW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // wrap units
   logic     div_start;
   logic     done_x, done_y;
   size_type x0, y0, x1, y1;
   logic [SIZE_W:0] x_next, y_next;

   assign div_start = cmd.load && (req_func == FUNC_SAMPLE);

   btsu_mod #(.IW(IW)) u_mod_x (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .value   (ix),
      .modulus (width_ff),
      .done    (done_x),
      .result  (x0)
   );

   btsu_mod #(.IW(IW)) u_mod_y (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .value   (iy),
      .modulus (height_ff),
      .done    (done_y),
      .result  (y0)
   );

   assign x_next = {1'b0, x0} + (SIZE_W + 1)'(1);
   assign y_next = {1'b0, y0} + (SIZE_W + 1)'(1);
   assign x1 = (x_next == {1'b0, width_ff})  ? '0 : x_next[SIZE_W-1:0];
   assign y1 = (y_next == {1'b0, height_ff}) ? '0 : y_next[SIZE_W-1:0];

   assign status.div_done   = done_x && done_y;
   assign status.clear_last = (clr_ff == LAST_ADDR);

   // texel address for the corner being fetched
   size_type      xsel, ysel;
   logic [AW-1:0] rd_addr;

   assign xsel = (cmd.corner == CORNER_UR || cmd.corner == CORNER_LR) ? x1 : x0;
   assign ysel = (cmd.corner == CORNER_LL || cmd.corner == CORNER_LR) ? y1 : y0;
   assign rd_addr = AW'(ysel) * ROW_PITCH + AW'(xsel);

   // single-port pixel store
   logic [TXW-1:0] mem [DEPTH];
   logic [TXW-1:0] rd_data_ff;
   logic [AW-1:0]  mem_addr;
   logic           mem_we;
   logic [TXW-1:0] mem_wdata;

   assign mem_addr  = cmd.clear ? clr_ff : (cmd.load ? wr_addr : rd_addr);
   assign mem_we    = cmd.clear || (cmd.load && req_func == FUNC_WRITE && wr_in_range);
   assign mem_wdata = cmd.clear ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end else if (cmd.mem_rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // fractional weights
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fx_ff <= req_coord_x[FRAC_BITS-1:0];
         fy_ff <= req_coord_y[FRAC_BITS-1:0];
      end
   end

   logic [WW-1:0] wv, wh;
   assign wv = (cmd.a_init || cmd.b_init) ? SCALE - WW'(fy_ff) : WW'(fy_ff);
   assign wh = cmd.t_init ? SCALE - WW'(fx_ff) : WW'(fx_ff);

   color_type sample_ff [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [CHANNEL_BITS-1:0] texel;
      logic [VW-1:0]           prod_v;
      logic [VW-1:0]           h_src;
      logic [TW-1:0]           prod_h;
      logic [VW-1:0]           a_ff, a_in;
      logic [VW-1:0]           b_ff, b_in;
      logic [TW-1:0]           t_ff, t_in;
      logic [TW-1:0]           rounded;

      assign texel  = rd_data_ff[c*CHANNEL_BITS +: CHANNEL_BITS];
      assign prod_v = VW'(wv) * VW'(texel);
      assign h_src  = cmd.t_init ? a_ff : b_ff;
      assign prod_h = TW'(wh) * TW'(h_src);

      always_comb begin
         a_in = a_ff;
         b_in = b_ff;
         t_in = t_ff;
         if (cmd.a_init) begin
            a_in = prod_v;
         end else if (cmd.a_add) begin
            a_in = a_ff + prod_v;
         end
         if (cmd.b_init) begin
            b_in = prod_v;
         end else if (cmd.b_add) begin
            b_in = b_ff + prod_v;
         end
         if (cmd.t_init) begin
            t_in = prod_h;
         end else if (cmd.t_add) begin
            t_in = t_ff + prod_h;
         end
      end

      always_ff @(posedge clock) begin
         a_ff <= a_in;
         b_ff <= b_in;
         t_ff <= t_in;
      end

      // round half up and drop both fraction fields
      assign rounded = t_ff + HALF;

      always_ff @(posedge clock) begin
         if (cmd.out_load) begin
            sample_ff[c] <= COLOR_W'(rounded[TW-1:2*FRAC_BITS]);
         end
      end
   end

   assign rsp_sample_red   = sample_ff[0];
   assign rsp_sample_green = sample_ff[1];
   assign rsp_sample_blue  = sample_ff[2];

endmodule

`default_nettype wire

@@ src/btsu_ctrl.sv @@
`default_nettype none
`include "bilinear_wrap_texture_sampler_unit_defines.svh"

module btsu_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_func,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output btsu_pkg::cmd_type    cmd,
   input  btsu_pkg::status_type status
);
   import btsu_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_RD_UL = 4'd3;
   localparam logic [3:0] ST_RD_LL = 4'd4;
   localparam logic [3:0] ST_RD_UR = 4'd5;
   localparam logic [3:0] ST_RD_LR = 4'd6;
   localparam logic [3:0] ST_H0    = 4'd7;
   localparam logic [3:0] ST_H1    = 4'd8;
   localparam logic [3:0] ST_H2    = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_func == FUNC_SAMPLE) state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_RD_UL;
         end
         ST_RD_UL: begin
            cmd.mem_rd = 1'b1;
            cmd.corner = CORNER_UL;
            state_in   = ST_RD_LL;
         end
         ST_RD_LL: begin
            cmd.mem_rd = 1'b1;
            cmd.corner = CORNER_LL;
            cmd.a_init = 1'b1;
            state_in   = ST_RD_UR;
         end
         ST_RD_UR: begin
            cmd.mem_rd = 1'b1;
            cmd.corner = CORNER_UR;
            cmd.a_add  = 1'b1;
            state_in   = ST_RD_LR;
         end
         ST_RD_LR: begin
            cmd.mem_rd = 1'b1;
            cmd.corner = CORNER_LR;
            cmd.b_init = 1'b1;
            state_in   = ST_H0;
         end
         ST_H0: begin
            cmd.b_add = 1'b1;
            state_in  = ST_H1;
         end
         ST_H1: begin
            cmd.t_init = 1'b1;
            state_in   = ST_H2;
         end
         ST_H2: begin
            cmd.t_add = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BTSU_ASSERT(a_out_slot_free, clock, reset, cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
   `BTSU_ASSERT(a_div_done_in_div, clock, reset, status.div_done |-> (state_ff == ST_DIV))
   `BTSU_ASSERT(a_clear_to_idle, clock, reset, (state_ff == ST_CLEAR && status.clear_last) |=> (state_ff == ST_IDLE))
   `BTSU_ASSERT(a_sample_starts, clock, reset, (req_valid && req_ready && req_func == FUNC_SAMPLE) |=> (state_ff == ST_DIV))
   `BTSU_ASSERT_ALWAYS(a_no_req_in_clear, clock, cmd.clear |-> !req_ready)

endmodule

`default_nettype wire

@@ src/bilinear_wrap_texture_sampler_unit.sv @@
// Bilinear texture sampler with wrap addressing.
//
// req_if carries one request: func 0 writes an RGB pixel at the integer part
// of coord_x/coord_y (ignored when outside the configured image), func 1
// samples at the signed fixed-point coordinate, wrapped modulo the image size.
// rsp_if returns one RGB result per sample request and nothing for writes.
// csr_* sets image_width (index 0) and image_height (index 1); write only while
// no request is in flight.
//
// Sequencing: a write is taken and the next request may follow at once. While
// a sample is in progress no further request is taken; it passes through the
// bit-serial wrap dividers (one remainder bit per cycle), four texel reads
// through the single port of the pixel store, and the two weighting passes
// and rounding. The next request can be taken in the same cycle in which
// rsp_if.valid rises.
// Reset: the store is swept to black, one texel a cycle, with req_if.ready
// low; the image size returns to 256 (saturated).
// A stalled receiver holds the result in the output register; a following
// write request is still taken, a further sample waits for the slot.
`default_nettype none

module bilinear_wrap_texture_sampler_unit #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int FRAC_BITS    = 8,
   parameter int CHANNEL_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   btsu_req_if.sink                 req_if,
   btsu_rsp_if.source               rsp_if,
   input  wire logic                csr_write_enable,
   input  btsu_pkg::csr_index_type  csr_index,
   input  btsu_pkg::csr_data_type   csr_write_data
);
   import btsu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: clearing sweep, divide wait, four corner reads, MAC passes
   btsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // store, size registers, wrap dividers, interpolation and output register
   btsu_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .FRAC_BITS    (FRAC_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_if.func),
      .req_coord_x      (req_if.coord_x),
      .req_coord_y      (req_if.coord_y),
      .req_write_red    (req_if.write_red),
      .req_write_green  (req_if.write_green),
      .req_write_blue   (req_if.write_blue),
      .rsp_sample_red   (rsp_if.sample_red),
      .rsp_sample_green (rsp_if.sample_green),
      .rsp_sample_blue  (rsp_if.sample_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

`default_nettype wire
